### design/pols_pkg.sv
// pols_pkg: shared types and constants for the Python outline line scanner.
// No dependencies.
package pols_pkg;

	typedef struct packed {
		logic [15:0] ch;
		logic        line_end;
	} pols_in_t;

	typedef struct packed {
		logic [20:0] line_number;
		logic        is_heading;
		logic        heading_kind;
		logic [3:0]  nest_level;
		logic [11:0] name_col;
		logic [11:0] name_len;
		logic        name_missing;
		logic        continues;
	} pols_out_t;

	// indent stack depth and line length limit; result field widths are sized for them
	localparam int MAX_NEST = 10;
	localparam int MAX_LINE = 4096;
	localparam logic [11:0] COL_MAX = 12'(MAX_LINE - 1);

	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_STRING   = 2'd1;
	localparam logic [1:0] MODE_CONTINUE = 2'd2;

	localparam logic [1:0] PH_INDENT = 2'd0;
	localparam logic [1:0] PH_BODY   = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;

	localparam logic [2:0] HD_NONE  = 3'd0;
	localparam logic [2:0] HD_START = 3'd1;
	localparam logic [2:0] HD_KW    = 3'd2;
	localparam logic [2:0] HD_SEP   = 3'd3;
	localparam logic [2:0] HD_AFTER = 3'd4;
	localparam logic [2:0] HD_WS    = 3'd5;
	localparam logic [2:0] HD_WORD  = 3'd6;
	localparam logic [2:0] HD_DONE  = 3'd7;

	localparam logic [0:0] REG_EXT_EOL = 1'b0;

	function automatic logic is_delim(input logic [15:0] c, input logic ext);
		return (c == 16'h000D) || (c == 16'h000A) ||
			(ext && ((c == 16'h0085) || (c == 16'h2028) || (c == 16'h2029)));
	endfunction

	function automatic logic is_word(input logic [15:0] c);
		return (c == 16'h005F) || (c >= 16'h0061 && c <= 16'h007A) ||
			(c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0030 && c <= 16'h0039);
	endfunction

	function automatic logic [15:0] kw_char(input logic kind, input logic [2:0] pos);
		logic [15:0] r;
		r = 16'h0;
		if (kind) begin
			case (pos)
				3'd0: r = 16'h0063;
				3'd1: r = 16'h006C;
				3'd2: r = 16'h0061;
				3'd3, 3'd4: r = 16'h0073;
				default: r = 16'h0;
			endcase
		end else begin
			case (pos)
				3'd0: r = 16'h0064;
				3'd1: r = 16'h0065;
				3'd2: r = 16'h0066;
				default: r = 16'h0;
			endcase
		end
		return r;
	endfunction

endpackage

### design/python_outline_line_scanner.sv
// python_outline_line_scanner: top level of the Python outline line scanner.
// Depends on pols_pkg and pols_judge.
//
//  channel | signals                        | payload
//  in      | in_valid, in_stall (out)       | pols_in_t  {ch, line_end}
//  out     | out_valid, out_stall (in)      | pols_out_t (one per line)
//  cfg     | APB psel/penable/pwrite/paddr  | extended_eol_enable at 0x0
//
// A unit that is not a line end is accepted whenever in_stall is low. At
// a line end the judge drains the lookahead buffer, one unit a cycle, and
// then picks the next step; for a heading line the indent stack is then
// searched one entry a cycle, and the result is loaded into the output
// register. in_stall is high during the drain, the search, the emit step
// and while the output register is full.
// Reset clears all control state and indent stack entry zero.
module python_outline_line_scanner import pols_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pols_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output pols_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
	localparam logic [NW-1:0] TOP_IDX = NW'(MAX_NEST - 1);

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_DRAIN = 4'b0010,
		ST_SRCH  = 4'b0100,
		ST_EMIT  = 4'b1000
	} st_t;

	st_t st_q;
	logic ext_q;
	logic [1:0] mode_q, phase_q, look_q, skip_q;
	logic quote_q, raw_q, long_q, prev_valid_q, scan_q;
	logic [15:0] prev_q;
	logic [15:0] buf_q [3];
	logic [11:0] indent_stack_q [MAX_NEST];
	logic [NW-1:0] top_q, idx_q;
	logic [11:0] col_q, indw_q, ncol_q, nlen_q;
	logic [20:0] line_q;
	logic [2:0] hd_q, hpos_q;
	logic hkind_q;
	logic heading_q;

	// config port
	assign pready = 1'b1;
	assign prdata = {31'd0, ext_q};
	wire cfg_wr = psel && penable && pwrite && (paddr[2] == REG_EXT_EOL);

	wire acc = in_valid && !in_stall;
	assign in_stall = (st_q != ST_RUN) || out_valid;

	// lookahead judge, shared by streaming and drain; while streaming the
	// newest lookahead unit is the one arriving this cycle
	logic [1:0] jr;
	logic [1:0] j_mode, j_skip;
	logic j_quote, j_raw, j_long, j_scan;
	wire [15:0] j_n2 = (st_q == ST_RUN) ? in_data.ch : buf_q[2];
	pols_judge u_judge (
		.c(buf_q[0]), .n1(buf_q[1]), .n2(j_n2), .r(jr), .ext(ext_q),
		.mode(mode_q), .quote(quote_q), .raw(raw_q), .long_s(long_q),
		.skip(skip_q), .prev_valid(prev_valid_q), .prev_unit(prev_q),
		.scan_on(scan_q), .mode_n(j_mode), .quote_n(j_quote), .raw_n(j_raw),
		.long_n(j_long), .skip_n(j_skip), .scan_n(j_scan)
	);

	// per-unit front end (indent, heading, buffering)
	logic [1:0] ph_n;
	logic scan_f, hd_start;
	logic [2:0] hd_n, hpos_n;
	logic hkind_n;
	logic [11:0] indw_n, ncol_n, nlen_n, tabw;
	logic [15:0] ch;
	logic sp;

	always_comb begin
		ch = in_data.ch;
		ph_n = phase_q;
		scan_f = scan_q;
		indw_n = indw_q;
		hd_start = 1'b0;
		tabw = (indw_q + 12'd8) & ~12'd7;
		if (phase_q == PH_INDENT) begin
			if (ch == 16'h0020) begin
				if (indw_q < COL_MAX) indw_n = indw_q + 12'd1;
			end else if (ch == 16'h0009) begin
				indw_n = ((indw_q + 12'd8 < indw_q) || tabw > COL_MAX) ? COL_MAX : tabw;
			end else if (is_delim(ch, ext_q) || ch == 16'h0 || ch == 16'h0023) begin
				ph_n = PH_SKIP;
			end else begin
				ph_n = PH_BODY;
				scan_f = 1'b1;
				hd_start = 1'b1;
			end
		end
		hd_n = hd_start ? HD_START : hd_q;
		hpos_n = hpos_q;
		hkind_n = hkind_q;
		ncol_n = ncol_q;
		nlen_n = nlen_q;
		sp = ch == 16'h0020 || ch == 16'h0009;
		if (ph_n == PH_BODY) begin
			case (hd_n)
				HD_START: begin
					if (ch == 16'h0064) begin
						hkind_n = 1'b0; hpos_n = 3'd1; hd_n = HD_KW;
					end else if (ch == 16'h0063) begin
						hkind_n = 1'b1; hpos_n = 3'd1; hd_n = HD_KW;
					end else hd_n = HD_NONE;
				end
				HD_KW: begin
					if (ch != kw_char(hkind_q, hpos_q)) begin
						hd_n = HD_NONE;
					end else begin
						hpos_n = hpos_q + 3'd1;
						if (hpos_n == (hkind_q ? 3'd5 : 3'd3)) hd_n = HD_SEP;
					end
				end
				HD_SEP: hd_n = sp ? HD_AFTER : HD_NONE;
				HD_AFTER, HD_WS: begin
					if (sp || is_delim(ch, ext_q)) hd_n = HD_WS;
					else if (is_word(ch)) begin
						ncol_n = col_q; nlen_n = 12'd1; hd_n = HD_WORD;
					end else begin
						ncol_n = col_q; nlen_n = 12'd0; hd_n = HD_DONE;
					end
				end
				HD_WORD: begin
					if (is_word(ch)) begin
						if (nlen_q < COL_MAX) nlen_n = nlen_q + 12'd1;
					end else hd_n = HD_DONE;
				end
				default: ;
			endcase
		end
		jr = (st_q == ST_DRAIN) ? look_q - 2'd1 : 2'd3;
	end

	// buffer full on a unit that is not a line end: judge the oldest unit
	wire run_judge = scan_f && look_q == 2'd2 && !in_data.line_end;
	wire is_hd = hd_q == HD_WS || hd_q == HD_WORD || hd_q == HD_DONE;
	wire [11:0] cur = indent_stack_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			ext_q <= 1'b0;
			mode_q <= MODE_NORMAL;
			quote_q <= 1'b0; raw_q <= 1'b0; long_q <= 1'b0;
			phase_q <= PH_INDENT;
			look_q <= 2'd0; skip_q <= 2'd0;
			prev_valid_q <= 1'b0; prev_q <= 16'd0; scan_q <= 1'b0;
			buf_q[0] <= 16'd0; buf_q[1] <= 16'd0; buf_q[2] <= 16'd0;
			indent_stack_q[0] <= 12'd0;
			top_q <= '0; idx_q <= '0;
			col_q <= 12'd0; indw_q <= 12'd0; ncol_q <= 12'd0; nlen_q <= 12'd0;
			line_q <= 21'd0;
			hd_q <= HD_NONE; hpos_q <= 3'd0; hkind_q <= 1'b0;
			heading_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_wr) ext_q <= pwdata[0];
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ST_RUN: if (acc) begin
					phase_q <= ph_n; indw_q <= indw_n;
					hd_q <= hd_n; hpos_q <= hpos_n; hkind_q <= hkind_n;
					ncol_q <= ncol_n; nlen_q <= nlen_n;
					if (col_q < COL_MAX) col_q <= col_q + 12'd1;
					scan_q <= run_judge ? j_scan : scan_f;
					if (scan_f) begin
						if (run_judge) begin
							// judge oldest, shift in new unit
							mode_q <= j_mode; quote_q <= j_quote; raw_q <= j_raw;
							long_q <= j_long; skip_q <= j_skip;
							prev_q <= buf_q[0]; prev_valid_q <= 1'b1;
							buf_q[0] <= buf_q[1]; buf_q[1] <= ch; buf_q[2] <= 16'd0;
						end else begin
							buf_q[look_q] <= ch;
							look_q <= look_q + 2'd1;
						end
					end else begin
						prev_q <= ch; prev_valid_q <= 1'b1;
					end
					if (in_data.line_end) st_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (scan_q && look_q != 2'd0) begin
						mode_q <= j_mode; quote_q <= j_quote; raw_q <= j_raw;
						long_q <= j_long; skip_q <= j_skip; scan_q <= j_scan;
						prev_q <= buf_q[0]; prev_valid_q <= 1'b1;
						buf_q[0] <= buf_q[1]; buf_q[1] <= buf_q[2]; buf_q[2] <= 16'd0;
						look_q <= look_q - 2'd1;
					end else begin
						heading_q <= is_hd;
						idx_q <= (32'(top_q) < MAX_NEST) ? top_q : TOP_IDX;
						st_q <= is_hd ? ST_SRCH : ST_EMIT;
						if (hd_q == HD_WS) begin
							ncol_q <= col_q; nlen_q <= 12'd0;
						end
					end
				end
				ST_SRCH: begin
					// one stack entry per cycle, from the top down
					if (indw_q == cur) begin
						top_q <= idx_q; st_q <= ST_EMIT;
					end else if (indw_q > cur && idx_q != TOP_IDX) begin
						top_q <= idx_q + NW'(1);
						indent_stack_q[idx_q + NW'(1)] <= indw_q;
						st_q <= ST_EMIT;
					end else if (idx_q == '0) begin
						st_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q - NW'(1);
					end
				end
				ST_EMIT: if (!out_valid) begin
					out_valid <= 1'b1;
					out_data.line_number <= line_q + 21'd1;
					out_data.is_heading <= heading_q;
					out_data.heading_kind <= heading_q & hkind_q;
					out_data.nest_level <= heading_q ? 4'(top_q) : 4'd0;
					out_data.name_col <= heading_q ? ncol_q : 12'd0;
					out_data.name_len <= heading_q ? nlen_q : 12'd0;
					out_data.name_missing <= heading_q && nlen_q == 12'd0;
					out_data.continues <= mode_q != MODE_NORMAL;
					line_q <= line_q + 21'd1;
					// start the next line
					if (mode_q == MODE_CONTINUE) mode_q <= MODE_NORMAL;
					phase_q <= (mode_q == MODE_NORMAL) ? PH_INDENT : PH_BODY;
					scan_q <= mode_q != MODE_NORMAL;
					col_q <= 12'd0; indw_q <= 12'd0; look_q <= 2'd0;
					buf_q[0] <= 16'd0; buf_q[1] <= 16'd0; buf_q[2] <= 16'd0;
					prev_q <= 16'd0; prev_valid_q <= 1'b0; skip_q <= 2'd0;
					hd_q <= HD_NONE; hkind_q <= 1'b0; hpos_q <= 3'd0;
					ncol_q <= 12'd0; nlen_q <= 12'd0;
					st_q <= ST_RUN;
				end
				default: st_q <= ST_RUN;
			endcase
		end
	end
endmodule

### design/pols_judge.sv
// pols_judge: lexical judge for one buffered code unit with two of lookahead.
// Depends on pols_pkg.
module pols_judge import pols_pkg::*; (
	input  logic [15:0] c,
	input  logic [15:0] n1,
	input  logic [15:0] n2,
	input  logic [1:0]  r,
	input  logic        ext,
	input  logic [1:0]  mode,
	input  logic        quote,
	input  logic        raw,
	input  logic        long_s,
	input  logic [1:0]  skip,
	input  logic        prev_valid,
	input  logic [15:0] prev_unit,
	input  logic        scan_on,
	output logic [1:0]  mode_n,
	output logic        quote_n,
	output logic        raw_n,
	output logic        long_n,
	output logic [1:0]  skip_n,
	output logic        scan_n
);
	logic [15:0] q;

	always_comb begin
		mode_n  = mode;
		quote_n = quote;
		raw_n   = raw;
		long_n  = long_s;
		skip_n  = skip;
		scan_n  = scan_on;
		q = quote ? 16'h0027 : 16'h0022;
		if (skip != 2'd0) begin
			skip_n = skip - 2'd1;
		end else if (c >= 16'hD800 && c <= 16'hDBFF && r >= 2'd1 &&
				n1 >= 16'hDC00 && n1 <= 16'hDFFF) begin
			skip_n = 2'd1;
		end else if (mode == MODE_STRING) begin
			if (c == 16'h005C && r >= 2'd1) begin
				if (!raw && (n1 == 16'h005C || n1 == 16'h0022 || n1 == 16'h0027)) begin
					skip_n = 2'd1;
				end else if (is_delim(n1, ext)) begin
					if (r < 2'd2 || n2 == n1) skip_n = 2'd1;
					else if (n2 == 16'h000A) skip_n = 2'd2;
				end
			end else if (is_delim(c, ext)) begin
				if (!long_s) mode_n = MODE_NORMAL;
			end else if (c == q) begin
				if (!long_s) begin
					mode_n = MODE_NORMAL;
				end else if (r >= 2'd2 && n1 == q && n2 == q) begin
					mode_n = MODE_NORMAL;
					skip_n = 2'd2;
				end
			end
		end else begin
			if (c == 16'h0023) begin
				mode_n = MODE_NORMAL;
				scan_n = 1'b0;
			end else if (c == 16'h0022 || c == 16'h0027) begin
				mode_n  = MODE_STRING;
				quote_n = (c == 16'h0027);
				raw_n   = prev_valid && (prev_unit == 16'h0072 || prev_unit == 16'h0052);
				if (r >= 2'd2 && n1 == c && n2 == c) begin
					long_n = 1'b1;
					skip_n = 2'd2;
				end else begin
					long_n = 1'b0;
				end
			end else if (c == 16'h005C) begin
				if ((r == 2'd2 && n1 == 16'h000D && n2 == 16'h000A) ||
						(r == 2'd1 && is_delim(n1, ext))) begin
					mode_n = MODE_CONTINUE;
					scan_n = 1'b0;
				end
			end
		end
	end
endmodule

### design/pols_checker.sv
// pols_checker: port-level assertions for the outline line scanner.
// Depends on pols_pkg; bound to python_outline_line_scanner.
module pols_checker import pols_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input pols_in_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input pols_out_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
	a_nomid: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_data.line_end |=> !out_valid || $past(out_valid))
		else $error("result mid-line");
	a_eol: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.line_end |=> in_stall) else $error("stall after eol");
	a_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_heading |-> out_data.nest_level == 4'd0 &&
		!out_data.name_missing) else $error("non-heading fields");
endmodule

bind python_outline_line_scanner pols_checker u_pols_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);

### tb/tb_python_outline_line_scanner.sv
// tb_python_outline_line_scanner: self-checking bench for the Python outline line scanner.
// Depends on pols_pkg and the python_outline_line_scanner RTL; predicts each line's
// result from its own lexer model and compares it with every output transfer.
module tb_python_outline_line_scanner;
	import pols_pkg::*;

	localparam int NEST = 10;
	localparam int COLMAX = 4095;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	pols_in_t    in_data;
	logic        out_valid;
	logic        out_stall;
	pols_out_t   out_data;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	python_outline_line_scanner dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Line predictor state
	// ---------------------------------------------------------------
	bit          ext_eol;
	logic [1:0]  lx_mode;
	bit          lx_squote, lx_raw, lx_long;
	int unsigned istack [NEST];
	int unsigned itop, col_cnt, ind_w, line_cnt;
	int unsigned la [3];
	int unsigned la_n, prev_u, skip_n;
	bit          prev_ok, scanning;
	logic [1:0]  phase;
	logic [2:0]  hd_st;
	bit          hd_cls;
	int unsigned hd_idx, nm_col, nm_len;

	pols_out_t   line_results [$];
	bit          failed;
	bit          idle_on;
	int          gap_left_in;

	function automatic bit delim_u(int unsigned c);
		if (c == 'h0D || c == 'h0A) return 1;
		return ext_eol && (c == 'h85 || c == 'h2028 || c == 'h2029);
	endfunction

	function automatic bit word_u(int unsigned c);
		return c == "_" || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9");
	endfunction

	task automatic lex_normal(int unsigned c, int unsigned n1, int unsigned n2, int unsigned r);
		if (c == "#") begin
			lx_mode = MODE_NORMAL;
			scanning = 0;
		end else if (c == "\"" || c == "'") begin
			lx_mode = MODE_STRING;
			lx_squote = (c == "'");
			lx_raw = prev_ok && (prev_u == "r" || prev_u == "R");
			if (r >= 2 && n1 == c && n2 == c) begin
				lx_long = 1;
				skip_n = 2;
			end else begin
				lx_long = 0;
			end
		end else if (c == "\\") begin
			if ((r == 2 && n1 == 'h0D && n2 == 'h0A) || (r == 1 && delim_u(n1))) begin
				lx_mode = MODE_CONTINUE;
				scanning = 0;
			end
		end
	endtask

	task automatic lex_string(int unsigned c, int unsigned n1, int unsigned n2, int unsigned r);
		int unsigned q;
		q = lx_squote ? "'" : "\"";
		if (c == "\\" && r >= 1) begin
			if (!lx_raw && (n1 == "\\" || n1 == "\"" || n1 == "'")) skip_n = 1;
			else if (delim_u(n1)) begin
				if (r < 2 || n2 == n1) skip_n = 1;
				else if (n2 == 'h0A) skip_n = 2;
			end
		end else if (delim_u(c)) begin
			if (!lx_long) lx_mode = MODE_NORMAL;
		end else if (c == q) begin
			if (!lx_long) lx_mode = MODE_NORMAL;
			else if (r >= 2 && n1 == q && n2 == q) begin
				lx_mode = MODE_NORMAL;
				skip_n = 2;
			end
		end
	endtask

	// r: units of the line known after the oldest buffered one (3 = more than 2)
	task automatic lex_judge(int unsigned r);
		int unsigned c, n1, n2;
		c = la[0]; n1 = la[1]; n2 = la[2];
		if (skip_n > 0) skip_n--;
		else if (c >= 'hD800 && c <= 'hDBFF && r >= 1 && n1 >= 'hDC00 && n1 <= 'hDFFF)
			skip_n = 1;
		else if (lx_mode == MODE_STRING) lex_string(c, n1, n2, r);
		else lex_normal(c, n1, n2, r);
		prev_u = c;
		prev_ok = 1;
		la[0] = n1; la[1] = n2; la[2] = 0;
		if (la_n > 0) la_n--;
	endtask

	task automatic heading_track(int unsigned c, int unsigned col);
		int unsigned klen;
		case (hd_st)
			HD_START: begin
				if (c == "d") begin hd_cls = 0; hd_idx = 1; hd_st = HD_KW; end
				else if (c == "c") begin hd_cls = 1; hd_idx = 1; hd_st = HD_KW; end
				else hd_st = HD_NONE;
			end
			HD_KW: begin
				klen = hd_cls ? 5 : 3;
				if (hd_idx >= klen) hd_st = HD_NONE;
				else if (c != kw_char(hd_cls, 3'(hd_idx)))
					hd_st = HD_NONE;
				else begin
					hd_idx++;
					if (hd_idx == klen) hd_st = HD_SEP;
				end
			end
			HD_SEP: hd_st = (c == " " || c == "\t") ? HD_AFTER : HD_NONE;
			HD_AFTER, HD_WS: begin
				if (c == " " || c == "\t" || delim_u(c)) hd_st = HD_WS;
				else if (word_u(c)) begin nm_col = col; nm_len = 1; hd_st = HD_WORD; end
				else begin nm_col = col; nm_len = 0; hd_st = HD_DONE; end
			end
			HD_WORD: begin
				if (word_u(c)) begin if (nm_len < COLMAX) nm_len++; end
				else hd_st = HD_DONE;
			end
			default: ;
		endcase
	endtask

	task automatic line_open();
		bit top;
		top = (lx_mode == MODE_NORMAL);
		if (lx_mode == MODE_CONTINUE) lx_mode = MODE_NORMAL;
		col_cnt = 0; ind_w = 0; la_n = 0;
		la[0] = 0; la[1] = 0; la[2] = 0;
		prev_u = 0; prev_ok = 0; skip_n = 0;
		hd_st = HD_NONE; hd_cls = 0; hd_idx = 0; nm_col = 0; nm_len = 0;
		phase = top ? PH_INDENT : PH_BODY;
		scanning = !top;
	endtask

	task automatic model_reset();
		ext_eol = 0;
		lx_mode = MODE_NORMAL;
		lx_squote = 0; lx_raw = 0; lx_long = 0;
		foreach (istack[i]) istack[i] = 0;
		itop = 0; line_cnt = 0;
		line_open();
	endtask

	// One accepted unit; at a line end the expected result is queued.
	task automatic predict_unit(int unsigned ch, bit last);
		int unsigned col, nd, i;
		bit hd;
		pols_out_t r;
		col = col_cnt;
		if (phase == PH_INDENT) begin
			if (ch == " ") begin
				if (ind_w < COLMAX) ind_w++;
			end else if (ch == "\t") begin
				nd = (ind_w + 8) & ~32'd7;
				ind_w = nd > COLMAX ? COLMAX : nd;
			end else if (delim_u(ch) || ch == 0 || ch == "#") begin
				phase = PH_SKIP;
			end else begin
				phase = PH_BODY;
				scanning = 1;
				hd_st = HD_START;
			end
		end
		if (phase == PH_BODY) heading_track(ch, col);
		if (scanning) begin
			if (la_n < 3) begin la[la_n] = ch; la_n++; end
			if (!last && la_n == 3) lex_judge(3);
		end else begin
			prev_u = ch;
			prev_ok = 1;
		end
		if (col < COLMAX) col_cnt = col + 1;
		if (!last) return;
		while (scanning && la_n > 0) lex_judge(la_n - 1);
		r = '0;
		hd = (hd_st == HD_WS || hd_st == HD_WORD || hd_st == HD_DONE);
		if (hd) begin
			i = itop < NEST ? itop : NEST - 1;
			forever begin
				if (ind_w == istack[i]) begin itop = i; break; end
				if (ind_w > istack[i] && i < NEST - 1) begin
					itop = i + 1;
					istack[i + 1] = ind_w;
					break;
				end
				if (i == 0) break;
				i--;
			end
			r.heading_kind = hd_cls;
			r.nest_level = 4'(itop);
			if (hd_st == HD_WS) begin r.name_col = 12'(col_cnt); r.name_len = 12'd0; end
			else begin r.name_col = 12'(nm_col); r.name_len = 12'(nm_len); end
		end
		line_cnt = (line_cnt + 1) & 'h1FFFFF;
		r.line_number = 21'(line_cnt);
		r.is_heading = hd;
		r.name_missing = hd && r.name_len == 12'd0;
		r.continues = (lx_mode != MODE_NORMAL);
		line_results.push_back(r);
		line_open();
	endtask

	// ---------------------------------------------------------------
	// Result checker and receiver stall bursts
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		pols_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (line_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				failed = 1;
			end else begin
				e = line_results.pop_front();
				if (out_data !== e) begin
					$display("%0t: result mismatch expected %p actual %p", $time, e, out_data);
					failed = 1;
				end
			end
		end
	end

	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 16);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	task automatic send_unit(int unsigned ch, bit last);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.ch <= ch[15:0];
		in_data.line_end <= last;
		do @(posedge clk); while (in_stall);
		predict_unit(ch, last);
	endtask

	// Sends a line of text; the delimiter code given is appended as its end.
	task automatic send_line(string s, int unsigned eol);
		for (int k = 0; k < s.len(); k++) send_unit(s[k], 0);
		if (eol == 'h0D0A) begin
			send_unit('h0D, 0);
			send_unit('h0A, 1);
		end else send_unit(eol, 1);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (line_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic apb_write_eol(bit v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {REG_EXT_EOL, 2'b00}; pwdata <= {31'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		ext_eol = v;
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	task automatic test_directed();
		send_line("def foo(x):", 'h0A);
		send_line("    class Bar_9:", 'h0A);
		send_line("\tdef", 'h0A);           // keyword only, no separator
		send_line("def  ", 'h0D0A);          // blanks only after keyword
		send_line("class (x)", 'h0A);        // name missing
		send_line("# comment", 'h0A);
		send_line("   ", 'h0A);               // blank line
		send_line("x = 1 + \\", 'h0D0A);     // trailing backslash
		send_line("  def cont():", 'h0A);    // continuation, not a heading
		send_line("s = \"\"\"long", 'h0A);
		send_line("def inside", 'h0A);
		send_line("end\"\"\" ", 'h0A);
		send_line("r'\\' # raw", 'h0A);
		send_line("a = 'un", 'h0A);          // short string ends at delimiter
		send_line("b = \"x\\", 'h0A);        // escaped delimiter keeps string
		send_line("c\"", 'h0A);
		send_unit('hD83D, 0); send_unit('hDE00, 0); send_unit("'", 0);
		send_unit('hD800, 0); send_unit('hFFFF, 0); send_unit('h0A, 1);
		send_unit(0, 0); send_unit('h0A, 1);
		send_unit('h2028, 1);
	endtask

	task automatic test_extended_eol();
		drain_results();
		apb_write_eol(1);
		send_line("def e():", 'h85);
		send_line("x = \\", 'h2028);
		send_line("y", 'h2029);
		send_unit('h85, 1);
		drain_results();
		apb_write_eol(0);
	endtask

	task automatic test_deep_nesting();
		for (int d = 0; d < 13; d++) begin
			string s;
			s = "";
			for (int k = 0; k < d; k++) s = {s, " "};
			send_line({s, "def n():"}, 'h0A);
		end
		send_line("def top():", 'h0A);
	endtask

	task automatic test_long_line();
		for (int k = 0; k < 100; k++) send_unit(" ", 0);
		send_unit("\t", 0);
		send_line("def a():", 'h0A);
		send_line("def ", 'h0A);
		for (int k = 0; k < 100; k++) send_unit("x", 0);
		send_unit('h0A, 1);
		send_unit("c", 0); send_unit("l", 0); send_unit("a", 0);
		send_unit("s", 0); send_unit("s", 0); send_unit(" ", 0);
		for (int k = 0; k < 100; k++) send_unit("_", 0);
		send_unit('h0A, 1);
	endtask

	function automatic int unsigned pick_unit();
		case ($urandom_range(0, 19))
			0: return $urandom_range(0, 65535);
			1: return "\\";
			2: return "\"";
			3: return "'";
			4: return "#";
			5: return "r";
			6: return "\t";
			7, 8: return " ";
			9: return $urandom_range(0, 1) ? 'hD800 + $urandom_range(0, 1023)
				: 'hDC00 + $urandom_range(0, 1023);
			10: return $urandom_range(0, 1) ? 'h0D : 'h85;
			11: return $urandom_range(0, 1) ? 'h2028 : 'h2029;
			default: return $urandom_range("a", "z");
		endcase
	endfunction

	task automatic test_random(int unsigned budget, bit with_idle);
		int unsigned sent;
		int unsigned ln;
		int unsigned eols [5] = '{'h0A, 'h0D, 'h85, 'h2028, 'h2029};
		idle_on = with_idle;
		sent = 0;
		while (sent < budget) begin
			string pre;
			pre = "";
			for (int k = $urandom_range(0, 12); k > 0; k--)
				pre = {pre, $urandom_range(0, 3) == 0 ? "\t" : " "};
			case ($urandom_range(0, 5))
				0: pre = {pre, "def "};
				1: pre = {pre, "class "};
				2: pre = {pre, $urandom_range(0, 1) ? "def\t" : "clas "};
				default: ;
			endcase
			for (int k = 0; k < pre.len(); k++) send_unit(pre[k], 0);
			ln = $urandom_range(0, 10);
			for (int k = 0; k < ln; k++) send_unit(pick_unit(), 0);
			if ($urandom_range(0, 3) == 0) send_unit("\\", 0);
			if ($urandom_range(0, 4) == 0) send_unit('h0D, 0);
			send_unit(eols[$urandom_range(0, 4)], 1);
			sent += pre.len() + ln + 2;
		end
	endtask

	initial begin
		failed = 0;
		idle_on = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0;
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1;
		test_directed();
		test_extended_eol();
		test_deep_nesting();
		test_long_line();
		drain_results();
		apb_write_eol(1);
		test_random(400, 1);
		drain_results();
		apb_write_eol(0);
		test_random(400, 1);
		test_random(250, 0);       // last stretch without idling
		drain_results();
		if (!failed) $display("tb_python_outline_line_scanner OK");
		else $display("tb_python_outline_line_scanner NOT OK");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_python_outline_line_scanner NOT OK");
		$finish;
	end

endmodule
